@@ rtl/ppmd_pkg.sv @@
package ppmd_pkg;
    localparam int NUM_CH = 8;
    localparam int CH_W = 3;
    localparam int OVF_LIMIT = 10;

    typedef enum logic [2:0] {
        CMD_CAPTURE  = 3'd0,
        CMD_OVERFLOW = 3'd1,
        CMD_READ     = 3'd2,
        CMD_MASK_NF  = 3'd3,
        CMD_MASK_LG  = 3'd4,
        CMD_CALIB    = 3'd5
    } t_cmd;

    localparam logic REG_TICKS = 1'b0;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] timestamp;
        logic [2:0]  channel;
        logic [7:0]  flag_mask;
        logic [7:0]  calib_frames;
    } t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } t_state;
endpackage

@@ rtl/ppmd_front.sv @@
module ppmd_front
    import ppmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [37:0] i_data,
    output logic        o_q_valid,
    input  logic        i_q_pop,
    output t_word       o_q_word
);
    t_word r_q [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push;
    t_word w;

    always_comb begin
        w.cmd          = i_data[2:0];
        w.timestamp    = i_data[18:3];
        w.channel      = i_data[21:19];
        w.flag_mask    = i_data[29:22];
        w.calib_frames = i_data[37:30];
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_word  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= w;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule

@@ rtl/ppmd_back.sv @@
module ppmd_back
    import ppmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic        i_cfg_hit,
    input  logic [15:0] i_cfg_data,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  t_word       i_q_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_data
);
    t_state r_st, n_st;
    logic [15:0] r_ticks;
    logic [15:0] r_w [NUM_CH];
    logic [15:0] r_off [NUM_CH];
    logic [23:0] r_sum [NUM_CH];
    logic [3:0]  r_cc, r_hs, r_ovf;
    logic [15:0] r_last;
    logic        r_nf;
    logic [1:0]  r_lg;
    logic [7:0]  r_fl, r_tot;
    logic [15:0] r_wv;
    logic [CH_W-1:0] r_j;
    logic [23:0] r_rem;
    logic [23:0] r_quo;
    logic [4:0]  r_bit;

    logic [35:0] gap;
    logic [19:0] dt;
    logic [3:0]  ovf_adj;
    logic        is_sync, frame_done;
    logic [3:0]  cc_inc;
    logic [24:0] trial;

    always_comb begin
        dt = {4'd0, i_q_word.timestamp} + 20'h10000 - {4'd0, r_last};
        ovf_adj = r_ovf;
        if (i_q_word.timestamp < r_last && r_ovf != 4'd0) ovf_adj = r_ovf - 4'd1;
        gap = {20'd0, dt[15:0]} + {16'd0, ovf_adj, 16'd0};
        is_sync = gap > ({20'd0, r_ticks} * 36'd6);
        cc_inc = (r_cc < 4'd15) ? r_cc + 4'd1 : r_cc;
        frame_done = !is_sync && cc_inc >= 4'd4 && r_lg != 2'd0 && cc_inc == r_hs;
        trial = {r_rem[23:0], r_sum[r_j][5'd23 - r_bit]} - {17'd0, r_tot};
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_q_valid) n_st = ST_EXEC;
            ST_EXEC: n_st = (i_q_word.cmd == CMD_CAPTURE && frame_done && r_fl != 8'd0)
                            ? ST_SUM : ST_OUT;
            ST_SUM:  if (r_j == CH_W'(NUM_CH - 1))
                         n_st = (r_fl == 8'd1) ? ST_DIV : ST_OUT;
            ST_DIV:  if (r_bit == 5'd23 && r_j == CH_W'(NUM_CH - 1)) n_st = ST_OUT;
            ST_OUT:  if (i_ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_st == ST_OUT) && i_ready;
        o_valid = (r_st == ST_OUT);
        o_data  = {(r_fl != 8'd0), r_hs, r_lg, r_nf, r_wv};
    end

    // default highest channel only matters at reset, which restores it to 8
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ticks <= 16'd1000;
            for (int k = 0; k < NUM_CH; k++) begin
                r_w[k] <= 16'd3000;
                r_off[k] <= 16'd0; r_sum[k] <= 24'd0;
            end
            r_hs <= 4'd8;
            r_cc <= 4'd0; r_ovf <= 4'd0; r_last <= 16'd0;
            r_nf <= 1'b0; r_lg <= 2'd0; r_fl <= 8'd0; r_tot <= 8'd0;
            r_j <= '0; r_bit <= 5'd0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid && i_cfg_hit && i_cfg_index == REG_TICKS)
                r_ticks <= i_cfg_data;
            if (r_st == ST_EXEC) begin
                r_wv <= 16'd0;
                r_j <= '0;
                case (i_q_word.cmd)
                    CMD_CAPTURE: begin
                        r_ovf <= 4'd0;
                        r_last <= i_q_word.timestamp;
                        if (is_sync) begin
                            r_hs <= r_cc; r_cc <= 4'd0;
                            if (r_lg == 2'd0) r_lg <= 2'd1;
                        end else begin
                            if (r_cc < 4'(NUM_CH)) r_w[r_cc[CH_W-1:0]] <= gap[15:0];
                            r_cc <= cc_inc;
                            if (cc_inc >= 4'd4 && r_lg != 2'd0) begin
                                r_lg <= 2'd2;
                                if (cc_inc == r_hs) r_nf <= 1'b1;
                            end
                        end
                    end
                    CMD_OVERFLOW: begin
                        if (r_ovf >= 4'(OVF_LIMIT)) begin
                            r_ovf <= 4'(OVF_LIMIT); r_lg <= 2'd0;
                        end else r_ovf <= r_ovf + 4'd1;
                    end
                    CMD_READ: r_wv <= r_w[i_q_word.channel] - r_off[i_q_word.channel];
                    CMD_MASK_NF: r_nf <= r_nf & i_q_word.flag_mask[0];
                    CMD_MASK_LG: r_lg <= r_lg & i_q_word.flag_mask[1:0];
                    CMD_CALIB: begin
                        for (int k = 0; k < NUM_CH; k++) begin
                            r_off[k] <= 16'd0; r_sum[k] <= 24'd0;
                        end
                        r_fl <= i_q_word.calib_frames;
                        r_tot <= i_q_word.calib_frames;
                        if (i_q_word.calib_frames != 8'd0) r_nf <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (r_st == ST_SUM) begin
                r_sum[r_j] <= r_sum[r_j] + {8'd0, r_w[r_j]} - {8'd0, r_off[r_j]};
                if (r_j == CH_W'(NUM_CH - 1)) begin
                    r_j <= '0;
                    r_bit <= 5'd0; r_rem <= 24'd0; r_quo <= 24'd0;
                    if (r_fl == 8'd1) r_fl <= 8'd0;
                    else begin r_fl <= r_fl - 8'd1; r_nf <= 1'b0; end
                    if (r_fl == 8'd1 && r_tot == 8'd0) r_fl <= 8'd0;
                end else r_j <= r_j + 1'b1;
            end
            if (r_st == ST_DIV) begin
                if (!trial[24]) begin
                    r_rem <= trial[23:0];
                    r_quo <= {r_quo[22:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[22:0], r_sum[r_j][5'd23 - r_bit]};
                    r_quo <= {r_quo[22:0], 1'b0};
                end
                if (r_bit == 5'd23) begin
                    r_off[r_j] <= trial[24] ? {r_quo[14:0], 1'b0} : {r_quo[14:0], 1'b1};
                    r_bit <= 5'd0; r_rem <= 24'd0; r_quo <= 24'd0;
                    r_j <= r_j + 1'b1;
                end else r_bit <= r_bit + 5'd1;
            end
        end
    end
endmodule

@@ rtl/ppm_frame_decoder.sv @@
// PPM frame decoder.
// Slave stream carries command words: capture edge, timer overflow, width
// read, flag masks and calibration start. Every word yields one status word
// on the master stream: width value (reads only), new-frame, link-good,
// highest channel and calibrating.
// A two-entry queue parts the input side from the execute unit, so words are
// taken while a status word waits on the master side.
// A capture that completes a calibration frame also adds the channel sums;
// the last such frame also runs the bit-serial divider (24 steps per channel,
// 8 channels).
// Reset restores register defaults and loads the width, offset and sum
// tables. A config write changes only the timing register; the tables and
// the highest channel keep their values. A stalled master side holds the
// status word and the queue fills; tready falls when it is full.
module ppm_frame_decoder
    import ppmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[2:0] timestamp[18:3] channel[21:19] flag_mask[29:22] calib_frames[37:30]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // width_value[15:0] new_frame[16] link_good[18:17] highest_channel[22:19]
    // calibrating[23]
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic  q_valid, q_pop;
    t_word q_word;

    assign o_cfg_ready = 1'b1;

    ppmd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata[37:0]),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_word(q_word)
    );

    ppmd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index[0]),
        .i_cfg_hit(i_cfg_index[7:1] == 7'd0), .i_cfg_data(i_cfg_data),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_word(q_word),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );
endmodule

@@ dv/ppmd_checker.sv @@
module ppmd_checker
    import ppmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [39:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] IDX_TICKS = 8'(REG_TICKS);
    localparam logic [7:0] IDX_DEFAULT_HI = 8'd1;

    typedef struct packed {
        logic        calibrating;
        logic [3:0]  highest_channel;
        logic [1:0]  link_good;
        logic        new_frame;
        logic [15:0] width_value;
    } t_status;

    // decoder registers and state
    logic [15:0] ticks;
    logic [3:0]  default_hi;
    logic [15:0] widths [NUM_CH];
    logic [15:0] offsets [NUM_CH];
    logic [23:0] sums [NUM_CH];
    logic [3:0]  ch_count;
    logic [3:0]  hi_seen;
    logic [15:0] last_cap;
    logic [3:0]  ovf_count;
    logic        nf_flag;
    logic [1:0]  link;
    logic [7:0]  frames_left;
    logic [7:0]  calib_total;

    t_status status_q[$];

    task automatic clear_state();
        for (int j = 0; j < NUM_CH; j++) begin
            widths[j] = 16'(32'(ticks) * 3);
            offsets[j] = '0;
            sums[j] = '0;
        end
        ch_count = '0;
        hi_seen = default_hi;
        last_cap = '0;
        ovf_count = '0;
        nf_flag = 1'b0;
        link = '0;
        frames_left = '0;
        calib_total = '0;
    endtask

    function automatic void frame_done();
        if (frames_left == 0)
            return;
        for (int j = 0; j < NUM_CH; j++)
            sums[j] = 24'(32'(sums[j]) + 32'(widths[j]) - 32'(offsets[j]));
        frames_left--;
        if (frames_left == 0) begin
            if (calib_total != 0)
                for (int j = 0; j < NUM_CH; j++)
                    offsets[j] = 16'(32'(sums[j]) / 32'(calib_total));
        end else begin
            nf_flag = 1'b0;
        end
    endfunction

    function automatic void take_edge(input logic [15:0] ts);
        int unsigned ovf;
        int unsigned gap;
        ovf = ovf_count;
        ovf_count = '0;
        gap = 32'(16'(ts - last_cap));
        if (ts < last_cap && ovf > 0)
            ovf--;
        gap += ovf << 16;
        last_cap = ts;
        if (gap > 32'(ticks) * 6) begin
            hi_seen = ch_count;
            ch_count = '0;
            if (link == 0)
                link = 2'd1;
        end else begin
            if (ch_count < NUM_CH)
                widths[ch_count[2:0]] = gap[15:0];
            if (ch_count < 15)
                ch_count++;
            if (ch_count >= 4 && link != 0) begin
                link = 2'd2;
                if (ch_count == hi_seen) begin
                    nf_flag = 1'b1;
                    frame_done();
                end
            end
        end
    endfunction

    function automatic t_status decode_word(input logic [39:0] w);
        t_status st;
        logic [2:0] cmd;
        logic [2:0] ch;
        logic [7:0] mask;
        logic [7:0] frames;
        cmd = w[2:0];
        ch = w[21:19];
        mask = w[29:22];
        frames = w[37:30];
        st = '0;
        case (cmd)
            CMD_CAPTURE: take_edge(w[18:3]);
            CMD_OVERFLOW: begin
                ovf_count++;
                if (ovf_count > OVF_LIMIT) begin
                    ovf_count = 4'(OVF_LIMIT);
                    link = '0;
                end
            end
            CMD_READ: if (ch < NUM_CH) st.width_value = widths[ch] - offsets[ch];
            CMD_MASK_NF: nf_flag &= mask[0];
            CMD_MASK_LG: link &= mask[1:0];
            CMD_CALIB: begin
                for (int j = 0; j < NUM_CH; j++) begin
                    offsets[j] = '0;
                    sums[j] = '0;
                end
                frames_left = frames;
                calib_total = frames;
                if (frames != 0)
                    nf_flag = 1'b0;
            end
            default: ;
        endcase
        st.new_frame = nf_flag;
        st.link_good = link;
        st.highest_channel = hi_seen;
        st.calibrating = (frames_left != 0);
        return st;
    endfunction

    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (!i_rst_n) begin
            ticks = 16'd1000;
            default_hi = 4'd8;
            clear_state();
            status_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == IDX_TICKS)
                    ticks = i_cfg_data;
                else if (i_cfg_index == IDX_DEFAULT_HI)
                    default_hi = i_cfg_data[3:0];
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (status_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t unexpected status word %h", $realtime, got);
                end else begin
                    want = status_q.pop_front();
                    if (got.width_value !== want.width_value
                        || got.new_frame !== want.new_frame
                        || got.link_good !== want.link_good
                        || got.highest_channel !== want.highest_channel
                        || got.calibrating !== want.calibrating) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t mismatch: wv %h/%h nf %b/%b lg %0d/%0d hc %0d/%0d cal %b/%b",
                                $realtime, want.width_value, got.width_value,
                                want.new_frame, got.new_frame, want.link_good, got.link_good,
                                want.highest_channel, got.highest_channel,
                                want.calibrating, got.calibrating);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                status_q.push_back(decode_word(i_in_data));
        end
        o_pending = status_q.size();
    end
endmodule

@@ dv/testbench.sv @@
module testbench;
    import ppmd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] IDX_TICKS = 8'(REG_TICKS);
    localparam logic [7:0] IDX_DEFAULT_HI = 8'd1;
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEMS_PER_PHASE = 360;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int cycles = 0;
    int words_sent = 0;
    logic word_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic steady = 1'b0;
    logic hold_off = 1'b0;
    logic [15:0] cur_ticks = 16'd1000;
    int unsigned now_ts = 0;

    always #4 i_clk = ~i_clk;

    ppm_frame_decoder dut (.*);

    ppmd_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        word_taken <= s_axis_tvalid && s_axis_tready;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ppm_frame_decoder regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= !hold_off && (steady || $urandom_range(99) >= 24);

    // long receiver stall while words keep coming
    initial begin
        wait (words_sent >= 500);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // tvalid stays up after a word; the next send may drop it, and settle takes it down
    task automatic send(input logic [2:0] cmd, input logic [15:0] ts, input logic [2:0] ch,
                        input logic [7:0] mask, input logic [7:0] frames);
        if (!steady && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, frames, mask, ch, ts, cmd};
        do @(negedge i_clk); while (!word_taken);
        words_sent++;
    endtask

    task automatic send_any(input logic [2:0] cmd, input logic [15:0] ts);
        send(cmd, ts, 3'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // advance the timer by a gap: overflow ticks for each wrap, then the edge
    task automatic pulse(input int unsigned gap);
        int unsigned wraps;
        wraps = ((now_ts & 32'hFFFF) + gap) >> 16;
        now_ts = now_ts + gap;
        repeat (wraps) send_any(CMD_OVERFLOW, 16'($urandom));
        send_any(CMD_CAPTURE, now_ts[15:0]);
    endtask

    task automatic frame(input int nch);
        int unsigned lo;
        int unsigned hi;
        lo = (cur_ticks * 2 > 0) ? cur_ticks * 2 : 1;
        hi = cur_ticks * 4;
        pulse(cur_ticks * 6 + $urandom_range(1, cur_ticks + 1));
        for (int k = 0; k < nch; k++)
            pulse($urandom_range(lo, hi));
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic random_phase(input int target);
        int start;
        int pick;
        start = words_sent;
        while (words_sent - start < target) begin
            pick = $urandom_range(99);
            if (pick < 60)
                frame($urandom_range(99) < 85 ? $urandom_range(4, 8) : $urandom_range(0, 11));
            else if (pick < 72)
                send_any(CMD_READ, 16'($urandom));
            else if (pick < 78)
                send(CMD_MASK_NF, 16'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 82)
                send(CMD_MASK_LG, 16'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 86)
                send(CMD_CALIB, 16'($urandom), 3'($urandom), 8'($urandom),
                     $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3)));
            else if (pick < 90)
                repeat ($urandom_range(1, 12)) send_any(CMD_OVERFLOW, 16'($urandom));
            else
                send_any(3'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        logic [15:0] tick_set [5] = '{16'd200, 16'd1, 16'd65535, 16'd300, 16'd150};
        logic [3:0]  hi_set [5] = '{4'd8, 4'd0, 4'd4, 4'd5, 4'd8};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed checks at reset settings
        for (int c = 0; c < NUM_CH; c++)
            send(CMD_READ, 16'hFFFF, 3'(c), 8'hFF, 8'hFF);
        send(CMD_CAPTURE, 16'h0000, 3'd0, 8'h00, 8'h00);
        send(CMD_CAPTURE, 16'hFFFF, 3'd7, 8'hFF, 8'hFF);
        send(CMD_OVERFLOW, 16'h0000, 3'd0, 8'h00, 8'h00);
        send(CMD_CAPTURE, 16'h0010, 3'd0, 8'h00, 8'h00);
        repeat (12) send(CMD_OVERFLOW, 16'hFFFF, 3'd7, 8'hFF, 8'hFF);
        send(CMD_CAPTURE, 16'h0005, 3'd0, 8'h00, 8'h00);
        send(CMD_MASK_LG, 16'h0000, 3'd0, 8'hFE, 8'h00);
        send(CMD_MASK_NF, 16'h0000, 3'd0, 8'h00, 8'h00);
        send(CMD_CALIB, 16'h0000, 3'd0, 8'h00, 8'h00);
        send(CMD_CALIB, 16'hFFFF, 3'd7, 8'hFF, 8'hFF);
        send(CMD_SPARE_LO, 16'hFFFF, 3'd7, 8'hFF, 8'hFF);
        send(CMD_SPARE_HI, 16'h0000, 3'd0, 8'h00, 8'h00);
        settle();

        for (int p = 0; p < 5; p++) begin
            write_reg(IDX_TICKS, tick_set[p]);
            write_reg(IDX_DEFAULT_HI, {12'($urandom), hi_set[p]});
            cur_ticks = tick_set[p];
            if (p == 3) begin
                @(posedge i_clk);
                steady = 1'b1;
                @(negedge i_clk);
            end
            // calibration over two well-formed frames
            if (p == 0) begin
                send(CMD_CALIB, 16'h0, 3'd0, 8'h0, 8'd2);
                repeat (4) frame(8);
            end
            random_phase(ITEMS_PER_PHASE);
            if (p == 3) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                steady = 1'b0;
                @(negedge i_clk);
            end
            settle();
        end

        if (fail_count == 0)
            $display("ppm_frame_decoder regression: pass");
        else
            $display("ppm_frame_decoder regression: fail");
        $finish;
    end
endmodule
